FILE: src/ffh_pkg.sv
package ffh_pkg;
	localparam int MAX_BLOCKS_D = 64;
	localparam int HEAP_BYTES_D = 65536;
	localparam int HEADER_BYTES_D = 32;
	localparam int ALIGN_BYTES_D = 8;
	localparam int ADDR_W = 16;
	localparam int LIM_W = 17;
	localparam int CNT_W = 7;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_MARK = 2'd1,
		OP_SWEEP = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_ZERO = 2'd1,
		ST_OOM = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	localparam logic [1:0] REG_HEAP_LIMIT = 2'd0;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
		logic free;
		logic marked;
	} entry_t;

	// command broadcast to every cell for one pass of the chain
	typedef struct packed {
		logic shift;
		logic sweep;
		logic mark;
		logic grant;
		logic split;
		logic append;
	} cell_ctl_t;
endpackage

FILE: src/ffh_if.sv
interface ffh_in_if import ffh_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [ADDR_W-1:0] request_size;
	logic [ADDR_W-1:0] candidate_address;
	modport source(output valid, op, request_size, candidate_address, input ready);
	modport sink(input valid, op, request_size, candidate_address, output ready);
endinterface

interface ffh_out_if import ffh_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [ADDR_W-1:0] payload_address;
	logic [CNT_W-1:0] freed_count;
	modport source(output valid, status, payload_address, freed_count, input ready);
	modport sink(input valid, status, payload_address, freed_count, output ready);
endinterface

FILE: src/ffh_cell.sv
// A table entry. The chain moves one place per cycle while shift is high;
// the head entry is examined and rewritten by the controller in passing.
module ffh_cell import ffh_pkg::*; (
	input logic clk,
	input logic shift,
	input entry_t prev,
	output entry_t cur
);
	entry_t e_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			e_q <= prev;
		end
	end

	assign cur = e_q;
endmodule

FILE: src/first_fit_heap_with_mark_sweep.sv
// First-fit heap allocator with mark and sweep.
// Channels: in_w (op, request_size, candidate_address) and out_w (status,
// payload_address, freed_count), valid/ready; a word moves when both high.
// Config: APB write to address 0 sets heap_limit (17 bits, reset 65536).
// The table is a ring of MAX_BLOCKS cells that rotates by one entry each
// cycle during a scan; the controller sees only the head cell. Every item
// scans for one full revolution of the ring in S_SCAN, then finishes in
// S_FIN and holds its result in S_OUT. One item is in work at a time: the
// next word is taken only once the block is back in S_IDLE.
// A split inserts an entry: during that revolution the cells behind the
// split point are held back one place by a one-entry carry register.
// A new block is written into the first unused slot as it passes the head.
// Reset empties the table (block count and heap top to zero). While the
// result is not taken, the block holds it and accepts no new word.
module first_fit_heap_with_mark_sweep import ffh_pkg::*; #(
	parameter int MAX_BLOCKS = MAX_BLOCKS_D,
	parameter int HEAP_BYTES = HEAP_BYTES_D,
	parameter int HEADER_BYTES = HEADER_BYTES_D,
	parameter int ALIGN_BYTES = ALIGN_BYTES_D
) (
	input logic clk,
	input logic arst_n,
	ffh_in_if.sink in_w,
	ffh_out_if.source out_w,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int BW = $clog2(MAX_BLOCKS + 1);
	localparam int AL_W = (ALIGN_BYTES > 1) ? $clog2(ALIGN_BYTES) : 1;
	localparam logic [LIM_W-1:0] HDR = LIM_W'(HEADER_BYTES);
	localparam logic [LIM_W-1:0] ALG = LIM_W'(ALIGN_BYTES);
	localparam logic [LIM_W-1:0] HEAPC = (HEAP_BYTES < 65536) ?
		LIM_W'(HEAP_BYTES) : LIM_W'(65536);
	localparam logic [BW-1:0] MAXB = BW'(MAX_BLOCKS);
	localparam logic [IW:0] LASTI = (IW+1)'(MAX_BLOCKS - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_FIN = 4'b0100,
		S_OUT = 4'b1000
	} state_t;

	state_t state_q;
	logic [LIM_W-1:0] limit_q, top_q, need_q;
	logic [BW-1:0] count_q;
	logic [IW:0] idx_q;
	logic [1:0] op_q;
	logic [ADDR_W-1:0] cand_q;
	logic done_q, carry_v_q, zero_q;
	entry_t carry_q;
	logic [1:0] status_q;
	logic [ADDR_W-1:0] paddr_q;
	logic [CNT_W-1:0] freed_q;

	entry_t cell_out [MAX_BLOCKS];
	entry_t head, wb;
	logic live, ins, shift;
	logic [LIM_W-1:0] left;
	logic [LIM_W-1:0] rounded, eff_lim;
	logic [LIM_W:0] grow;
	logic over, app;
	entry_t app_e;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_HEAP_LIMIT) ? {15'd0, limit_q} : 32'd0;

	// rounding of request size to the alignment
	always_comb begin
		rounded = LIM_W'(in_w.request_size) + ALG - LIM_W'(1);
		rounded[AL_W-1:0] = (ALIGN_BYTES > 1) ? '0 : rounded[AL_W-1:0];
		eff_lim = (limit_q < HEAPC) ? limit_q : HEAPC;
	end

	// growth at the heap top
	assign grow = {1'b0, top_q} + {1'b0, HDR} + {1'b0, need_q};
	assign over = grow > {1'b0, eff_lim};
	assign app_e = '{start: top_q[ADDR_W-1:0], size: need_q[ADDR_W-1:0],
		free: 1'b0, marked: 1'b0};
	assign app = (state_q == S_SCAN) && op_t'(op_q) == OP_ALLOC && !done_q &&
		idx_q == (IW+1)'(count_q) && !over;

	assign head = carry_v_q ? carry_q : cell_out[0];
	assign live = (state_q == S_SCAN) && ({1'b0, idx_q} < {1'b0, count_q});
	assign left = LIM_W'(head.size) - need_q;
	assign shift = (state_q == S_SCAN);

	// rewrite of the head entry; ins inserts the split remainder behind it
	always_comb begin
		wb = head;
		ins = 1'b0;
		if (live && !done_q) begin
			case (op_t'(op_q))
				OP_ALLOC: begin
					if (head.free && LIM_W'(head.size) >= need_q) begin
						wb.free = 1'b0;
						wb.marked = 1'b0;
						if (left >= HDR + ALG && count_q < MAXB) begin
							wb.size = need_q[ADDR_W-1:0];
							ins = 1'b1;
						end
					end
				end
				OP_MARK: begin
					if (LIM_W'(head.start) + HDR == LIM_W'(cand_q) && !head.free &&
						LIM_W'(cand_q) < top_q) begin
						wb.marked = 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (live && op_t'(op_q) == OP_SWEEP && !head.free) begin
			wb.free = !head.marked;
			wb.marked = 1'b0;
		end
		if (app) begin
			wb = app_e;
		end
	end

	// ring: cell 0 is head; head result enters the tail
	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		entry_t nxt;
		if (g == MAX_BLOCKS - 1) begin : g_tail
			assign nxt = wb;
		end else begin : g_mid
			assign nxt = cell_out[g+1];
		end
		ffh_cell u_cell (
			.clk(clk),
			.shift(shift),
			.prev(nxt),
			.cur(cell_out[g])
		);
	end

	assign in_w.ready = (state_q == S_IDLE);
	assign out_w.valid = (state_q == S_OUT);
	assign out_w.status = status_q;
	assign out_w.payload_address = paddr_q;
	assign out_w.freed_count = freed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= LIM_W'(65536);
			top_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			done_q <= 1'b0;
			carry_v_q <= 1'b0;
			zero_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_HEAP_LIMIT) begin
				limit_q <= pwdata[LIM_W-1:0];
			end
			case (state_q)
				S_IDLE: begin
					if (in_w.valid) begin
						op_q <= in_w.op;
						cand_q <= in_w.candidate_address;
						need_q <= rounded;
						zero_q <= (in_w.request_size == '0);
						idx_q <= '0;
						done_q <= (in_w.op == OP_ALLOC && in_w.request_size == '0);
						status_q <= ST_OK;
						paddr_q <= '0;
						freed_q <= '0;
						carry_v_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// a pending carry entry takes the head's place; the real
					// head waits in the carry register until it is passed on
					if (ins) begin
						carry_q <= '{start: head.start + HDR[ADDR_W-1:0] + need_q[ADDR_W-1:0],
							size: left[ADDR_W-1:0] - HDR[ADDR_W-1:0], free: 1'b1, marked: 1'b0};
						carry_v_q <= 1'b1;
					end else if (carry_v_q) begin
						carry_q <= cell_out[0];
					end
					if (live && !done_q && op_t'(op_q) == OP_ALLOC && head.free &&
						LIM_W'(head.size) >= need_q) begin
						done_q <= 1'b1;
						paddr_q <= head.start + HDR[ADDR_W-1:0];
						if (ins) count_q <= count_q + BW'(1);
					end
					if (live && !done_q && op_t'(op_q) == OP_MARK &&
						wb.marked && !head.marked) begin
						done_q <= 1'b1;
					end else if (live && !done_q && op_t'(op_q) == OP_MARK &&
						LIM_W'(head.start) + HDR == LIM_W'(cand_q) && !head.free &&
						LIM_W'(cand_q) < top_q) begin
						done_q <= 1'b1;
					end
					if (live && op_t'(op_q) == OP_SWEEP && !head.free && !head.marked &&
						freed_q != '1) begin
						freed_q <= freed_q + CNT_W'(1);
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == LASTI) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					carry_v_q <= 1'b0;
					case (op_t'(op_q))
						OP_ALLOC: begin
							if (zero_q) begin
								status_q <= ST_ZERO;
							end else if (!done_q) begin
								if (count_q >= MAXB || over) begin
									status_q <= ST_OOM;
								end else begin
									paddr_q <= top_q[ADDR_W-1:0] + HDR[ADDR_W-1:0];
									top_q <= grow[LIM_W-1:0];
									count_q <= count_q + BW'(1);
								end
							end
						end
						OP_MARK: begin
							if (!done_q) status_q <= ST_MISS;
						end
						default: ;
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_w.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_w.valid && !out_w.ready |=> out_w.valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAXB)
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= LIM_W'(65536))
		else $error("heap top overflow");
endmodule

FILE: verif/ffh_tb_if.sv
`timescale 1ns / 100ps
// The interfaces used by the block are in src/ffh_if.sv; this file holds the
// testbench-side register-port bundle.
interface ffh_apb_if ();
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	modport source(output psel, penable, pwrite, paddr, pwdata, input prdata, pready);
	modport sink(input psel, penable, pwrite, paddr, pwdata, output prdata, pready);
endinterface

FILE: verif/tb_first_fit_heap_with_mark_sweep.sv
`timescale 1ns / 100ps
module tb_first_fit_heap_with_mark_sweep;
	import ffh_pkg::*;

	typedef struct {
		op_t op;
		logic [15:0] size;
		logic [15:0] addr;
		bit known;
		status_t st;
		logic [15:0] pay;
		logic [6:0] freed;
	} row_t;

	typedef struct {
		status_t st;
		logic [15:0] pay;
		logic [6:0] freed;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	ffh_in_if in_w ();
	ffh_out_if out_w ();
	ffh_apb_if apb ();

	first_fit_heap_with_mark_sweep i_dut (
		.clk(clk), .arst_n(arst_n), .in_w(in_w.sink), .out_w(out_w.source),
		.psel(apb.psel), .penable(apb.penable), .pwrite(apb.pwrite),
		.paddr(apb.paddr), .pwdata(apb.pwdata), .prdata(apb.prdata),
		.pready(apb.pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// heap shadow
	logic [16:0] lim_q;
	logic [16:0] hs_start [MAX_BLOCKS_D];
	logic [16:0] hs_size [MAX_BLOCKS_D];
	bit hs_free [MAX_BLOCKS_D];
	bit hs_mark [MAX_BLOCKS_D];
	int hs_cnt;
	logic [16:0] hs_top;
	logic [15:0] live [$];

	word_t pending [$];
	int errors = 0;
	int idle_cycles = 0;
	bit drain = 1'b0;
	bit hold_rx = 1'b0;
	bit calm = 1'b0;

	function automatic word_t heap_step(op_t op, logic [15:0] req, logic [15:0] addr);
		word_t w;
		int need, f, k, left, lim, freed;
		w.st = ST_OK;
		w.pay = '0;
		w.freed = '0;
		f = -1;
		if (op == OP_ALLOC) begin
			if (req == 0) begin
				w.st = ST_ZERO;
				return w;
			end
			need = ((int'(req) + ALIGN_BYTES_D - 1) / ALIGN_BYTES_D) * ALIGN_BYTES_D;
			for (k = 0; k < hs_cnt; k++)
				if (f < 0 && hs_free[k] && hs_size[k] >= need) f = k;
			if (f >= 0) begin
				left = hs_size[f] - need;
				if (left >= HEADER_BYTES_D + ALIGN_BYTES_D && hs_cnt < MAX_BLOCKS_D) begin
					for (k = hs_cnt; k > f + 1; k--) begin
						hs_start[k] = hs_start[k-1];
						hs_size[k] = hs_size[k-1];
						hs_free[k] = hs_free[k-1];
						hs_mark[k] = hs_mark[k-1];
					end
					hs_start[f+1] = hs_start[f] + HEADER_BYTES_D + need;
					hs_size[f+1] = left - HEADER_BYTES_D;
					hs_free[f+1] = 1'b1;
					hs_mark[f+1] = 1'b0;
					hs_size[f] = need;
					hs_cnt++;
				end
				hs_free[f] = 1'b0;
				hs_mark[f] = 1'b0;
				w.pay = 16'(hs_start[f] + HEADER_BYTES_D);
				live.push_back(w.pay);
				return w;
			end
			lim = lim_q;
			if (lim > HEAP_BYTES_D) lim = HEAP_BYTES_D;
			if (hs_cnt >= MAX_BLOCKS_D || int'(hs_top) + HEADER_BYTES_D + need > lim) begin
				w.st = ST_OOM;
				return w;
			end
			hs_start[hs_cnt] = hs_top;
			hs_size[hs_cnt] = need;
			hs_free[hs_cnt] = 1'b0;
			hs_mark[hs_cnt] = 1'b0;
			hs_cnt++;
			w.pay = 16'(hs_top + HEADER_BYTES_D);
			live.push_back(w.pay);
			hs_top = hs_top + HEADER_BYTES_D + need;
		end else if (op == OP_MARK) begin
			if (hs_cnt != 0 && addr < hs_top)
				for (k = 0; k < hs_cnt; k++)
					if (f < 0 && hs_start[k] + HEADER_BYTES_D == addr && !hs_free[k]) f = k;
			if (f >= 0) hs_mark[f] = 1'b1;
			else w.st = ST_MISS;
		end else if (op == OP_SWEEP) begin
			freed = 0;
			for (k = 0; k < hs_cnt; k++)
				if (!hs_free[k]) begin
					if (!hs_mark[k]) begin
						hs_free[k] = 1'b1;
						if (freed < 127) freed++;
					end else hs_mark[k] = 1'b0;
				end
			w.freed = 7'(freed);
		end
		return w;
	endfunction

	task automatic reg_write(logic [16:0] v);
		apb.psel <= 1'b1;
		apb.penable <= 1'b0;
		apb.pwrite <= 1'b1;
		apb.paddr <= {REG_HEAP_LIMIT[0], 1'b0} & 2'b00;
		apb.pwdata <= 32'(v);
		@(posedge clk);
		apb.penable <= 1'b1;
		@(posedge clk);
		while (!apb.pready) @(posedge clk);
		apb.psel <= 1'b0;
		apb.penable <= 1'b0;
		apb.pwrite <= 1'b0;
		lim_q = v;
	endtask

	task automatic send(op_t op, logic [15:0] sz, logic [15:0] ad, bit known, word_t kw);
		word_t w;
		in_w.valid <= 1'b1;
		in_w.op <= op;
		in_w.request_size <= sz;
		in_w.candidate_address <= ad;
		@(posedge clk);
		while (!in_w.ready) @(posedge clk);
		w = heap_step(op, sz, ad);
		if (known && (w.st != kw.st || w.pay != kw.pay || w.freed != kw.freed)) begin
			errors++;
			if (errors <= 10) $display("table row disagrees with heap shadow: op %0d", op);
		end
		pending.push_back(w);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_w.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic quiesce();
		in_w.valid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic rand_item(int alloc_w);
		int r;
		logic [15:0] sz, ad;
		word_t z;
		z = '{ST_OK, '0, '0};
		r = $urandom_range(0, 99);
		sz = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
		ad = 16'($urandom);
		if (live.size() != 0 && $urandom_range(0, 3) != 0)
			ad = live[$urandom_range(0, live.size() - 1)];
		if (r < alloc_w) send(OP_ALLOC, sz, ad, 1'b0, z);
		else if (r < 88) send(OP_MARK, sz, ad, 1'b0, z);
		else if (r < 97) send(OP_SWEEP, sz, ad, 1'b0, z);
		else send(OP_NONE, sz, ad, 1'b0, z);
	endtask

	// receiver
	always @(posedge clk) begin
		word_t e;
		if (out_w.valid && out_w.ready) begin
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected word: st %0d", out_w.status);
			end else begin
				e = pending.pop_front();
				if (out_w.status !== e.st || out_w.payload_address !== e.pay ||
						out_w.freed_count !== e.freed) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp st %0d pay %h freed %0d, got st %0d pay %h freed %0d",
							e.st, e.pay, e.freed, out_w.status, out_w.payload_address,
							out_w.freed_count);
				end
			end
		end
	end

	logic [2:0] rx_gap = 0;
	always @(posedge clk) begin
		if (hold_rx) out_w.ready <= 1'b0;
		else if (rx_gap != 0) begin
			out_w.ready <= 1'b0;
			rx_gap <= rx_gap - 3'd1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			out_w.ready <= 1'b0;
			rx_gap <= 3'($urandom_range(0, 5));
		end else out_w.ready <= 1'b1;
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("tb_first_fit_heap_with_mark_sweep: done, errors");
			$finish;
		end
	end

	row_t dir [] = '{
		'{OP_MARK, 16'd0, 16'd32, 1'b1, ST_MISS, 16'd0, 7'd0},
		'{OP_SWEEP, 16'd0, 16'd0, 1'b1, ST_OK, 16'd0, 7'd0},
		'{OP_ALLOC, 16'd0, 16'd0, 1'b1, ST_ZERO, 16'd0, 7'd0},
		'{OP_ALLOC, 16'd1, 16'd0, 1'b1, ST_OK, 16'd32, 7'd0},
		'{OP_ALLOC, 16'd100, 16'd0, 1'b1, ST_OK, 16'd72, 7'd0},
		'{OP_ALLOC, 16'hffff, 16'd0, 1'b1, ST_OOM, 16'd0, 7'd0},
		'{OP_MARK, 16'd0, 16'd72, 1'b1, ST_OK, 16'd0, 7'd0},
		'{OP_MARK, 16'd0, 16'd73, 1'b1, ST_MISS, 16'd0, 7'd0},
		'{OP_MARK, 16'd0, 16'hffff, 1'b1, ST_MISS, 16'd0, 7'd0},
		'{OP_SWEEP, 16'd0, 16'd0, 1'b1, ST_OK, 16'd0, 7'd1},
		'{OP_MARK, 16'd0, 16'd32, 1'b1, ST_MISS, 16'd0, 7'd0},
		'{OP_ALLOC, 16'd8, 16'd0, 1'b1, ST_OK, 16'd32, 7'd0},
		'{OP_NONE, 16'hffff, 16'hffff, 1'b1, ST_OK, 16'd0, 7'd0},
		'{OP_SWEEP, 16'd0, 16'd0, 1'b0, ST_OK, 16'd0, 7'd0},
		'{OP_ALLOC, 16'd40, 16'd0, 1'b0, ST_OK, 16'd0, 7'd0},
		'{OP_ALLOC, 16'd16, 16'd0, 1'b0, ST_OK, 16'd0, 7'd0},
		'{OP_ALLOC, 16'd7, 16'd0, 1'b0, ST_OK, 16'd0, 7'd0},
		'{OP_ALLOC, 16'hfe00, 16'd0, 1'b0, ST_OK, 16'd0, 7'd0},
		'{OP_ALLOC, 16'h5555, 16'h5555, 1'b0, ST_OK, 16'd0, 7'd0},
		'{OP_MARK, 16'haaaa, 16'haaaa, 1'b0, ST_OK, 16'd0, 7'd0}
	};

	initial begin
		int n;
		word_t kw;
		in_w.valid = 1'b0;
		in_w.op = OP_NONE;
		in_w.request_size = '0;
		in_w.candidate_address = '0;
		out_w.ready = 1'b0;
		apb.psel = 1'b0;
		apb.penable = 1'b0;
		apb.pwrite = 1'b0;
		apb.paddr = '0;
		apb.pwdata = '0;
		lim_q = 17'h10000;
		hs_cnt = 0;
		hs_top = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i]) begin
			kw = '{dir[i].st, dir[i].pay, dir[i].freed};
			send(dir[i].op, dir[i].size, dir[i].addr, dir[i].known, kw);
		end
		quiesce();

		// tight limit: exercises out of memory on growth
		reg_write(17'd600);
		for (n = 0; n < 60; n++) rand_item(55);
		quiesce();

		// limit zero, then all-ones
		reg_write(17'd0);
		for (n = 0; n < 10; n++) rand_item(60);
		quiesce();
		reg_write(17'h1ffff);

		// receiver holds off; sender keeps offering
		fork
			begin
				hold_rx = 1'b1;
				repeat (400) @(posedge clk);
				hold_rx = 1'b0;
			end
			for (n = 0; n < 20; n++) rand_item(60);
		join
		quiesce();

		// small chunks to fill the table up to its 64 entries
		reg_write(17'h10000);
		for (n = 0; n < 200; n++) rand_item(60);
		quiesce();

		reg_write(17'd4000);
		calm = 1'b1;
		for (n = 0; n < 100; n++) rand_item(50);
		quiesce();

		if (errors == 0) $display("tb_first_fit_heap_with_mark_sweep: done, clean");
		else $display("tb_first_fit_heap_with_mark_sweep: done, errors");
		$finish;
	end
endmodule
